/* rtl/msort_pkg.sv */
// Shared types and constants of the merge-insertion sorter.
package msort_pkg;

  // Width of one stored value
  localparam int unsigned VAL_W = 31;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_ORD  = 6'b001000,
    S_OUT  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture incoming item, start insertion at top of store
    logic rd_pos;   // read entry below the insertion point
    logic shift;    // move read entry up one place, step insertion point down
    logic place;    // write new value at insertion point, count it
    logic rd_out;   // read entry at output index
    logic out_adv;  // step output index
    logic clear;    // empty the store after a run
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pos_zero;   // insertion point at bottom of store
    logic greater;    // read entry is greater than new value
    logic fill_last;  // one free entry left before this placement
    logic last_q;     // captured item closes the set
    logic out_last;   // output index on greatest value
  } status_t;

endpackage

/* rtl/msort_item_if.sv */
// Input channel carrying one value of the set per transaction.
interface msort_item_if;
  logic                           valid;
  logic                           ready;
  logic [msort_pkg::VAL_W-1:0]    value;
  logic                           last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

/* rtl/msort_result_if.sv */
// Output channel carrying one sorted value per transaction.
interface msort_result_if;
  logic                           valid;
  logic                           ready;
  logic [msort_pkg::VAL_W-1:0]    sorted_value;
  logic                           final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

/* rtl/msort_dpath.sv */
// Datapath: sorted value store, insertion point, fill count and output index.
module msort_dpath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [msort_pkg::VAL_W-1:0]  in_value_i,
  input  logic                         in_last_i,
  input  msort_pkg::cmd_t              cmd_i,
  output msort_pkg::status_t           status_o,
  output logic [msort_pkg::VAL_W-1:0]  out_value_o,
  output logic                         out_final_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [msort_pkg::VAL_W-1:0] mem [CAPACITY];
  logic [msort_pkg::VAL_W-1:0] value_q;
  logic                        last_q;
  logic [msort_pkg::VAL_W-1:0] rdata_q;
  logic [CW-1:0]               fill_q, fill_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               rd_addr;

  // Pick the read address: below the insertion point, or the output index
  assign rd_addr = cmd_i.rd_pos ? (pos_q - AW'(1)) : idx_q;

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      mem[pos_q] <= rdata_q;
    end else if (cmd_i.place) begin
      mem[pos_q] <= value_q;
    end
    if (cmd_i.rd_pos || cmd_i.rd_out) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_value_i;
      last_q  <= in_last_i;
    end
  end

  // Advance counters
  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    idx_d  = idx_q;
    if (cmd_i.load) begin
      pos_d = fill_q[AW-1:0];
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - AW'(1);
    end
    if (cmd_i.place) begin
      fill_d = fill_q + CW'(1);
    end
    if (cmd_i.out_adv) begin
      idx_d = idx_q + AW'(1);
    end
    if (cmd_i.clear) begin
      fill_d = '0;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
      idx_q  <= '0;
    end else begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
      idx_q  <= idx_d;
    end
  end

  // Report status
  assign status_o.pos_zero  = (pos_q == '0);
  assign status_o.greater   = (rdata_q > value_q);
  assign status_o.fill_last = (fill_q == CW'(CAPACITY - 1));
  assign status_o.last_q    = last_q;
  assign status_o.out_last  = ((CW'(idx_q) + CW'(1)) == fill_q);

  // Drive result payload from the read register
  assign out_value_o = rdata_q;
  assign out_final_o = status_o.out_last;

endmodule

/* rtl/msort_ctrl.sv */
// Controller: sequences insertion of each value and readout of the set.
module msort_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  msort_pkg::status_t  status_i,
  output msort_pkg::cmd_t     cmd_o
);

  msort_pkg::state_e state_q, state_d;
  logic              closes;

  // Set closes on the last flag or on the placement that fills the store
  assign closes = status_i.last_q || status_i.fill_last;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      msort_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = msort_pkg::S_READ;
        end
      end
      // Place at the bottom, or fetch the entry below
      msort_pkg::S_READ: begin
        if (status_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = closes ? msort_pkg::S_ORD : msort_pkg::S_IDLE;
        end else begin
          cmd_o.rd_pos = 1'b1;
          state_d      = msort_pkg::S_CMP;
        end
      end
      // Shift a greater entry up, else place here
      msort_pkg::S_CMP: begin
        if (status_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = msort_pkg::S_READ;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = closes ? msort_pkg::S_ORD : msort_pkg::S_IDLE;
        end
      end
      msort_pkg::S_ORD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = msort_pkg::S_OUT;
      end
      // Hold the result until taken
      msort_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = msort_pkg::S_DONE;
          end else begin
            cmd_o.out_adv = 1'b1;
            state_d       = msort_pkg::S_ORD;
          end
        end
      end
      // Empty the store for the next set
      msort_pkg::S_DONE: begin
        cmd_o.clear = 1'b1;
        state_d     = msort_pkg::S_IDLE;
      end
      default: begin
        state_d = msort_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msort_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/merge_insertion_sorter.sv */
// Top level of the merge-insertion sorter.
//
//   channel    modport  payload                   role
//   item_i     sink     value[30:0], last         values of the set to sort
//   result_o   source   sorted_value[30:0], final ascending values of the set
//
// Each value is inserted into a sorted store held in one memory; each step down
// the store is a read in S_READ, then a compare and write in S_CMP. An item is
// placed in S_READ on reaching the bottom of the store, else in S_CMP, once each
// greater stored value has moved up. Readout reads each value in S_ORD and
// offers it in S_OUT until the receiver takes it; S_DONE then empties the store.
// No item is taken while an item is being inserted or a set read out.
// Reset empties the store at once; memory contents are not cleared.
module merge_insertion_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  msort_item_if.sink         item_i,
  msort_result_if.source     result_o
);

  msort_pkg::cmd_t    cmd;
  msort_pkg::status_t status;

  msort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msort_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (item_i.value),
    .in_last_i   (item_i.last),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_value_o (result_o.sorted_value),
    .out_final_o (result_o.final_res)
  );

`ifndef SYNTH
  // Never take an item while a result is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(item_i.ready && result_o.valid))
    else $error("item taken while result pending");

  // Busy after taking an item
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("ready right after item transaction");

  // Closing result is followed by clearing, then a new set may start
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.ready && result_o.final_res)
      |=> (!result_o.valid && !item_i.ready) ##1 item_i.ready)
    else $error("store not reopened after final result");
`endif

endmodule

/* bench/merge_insertion_sorter_checker.sv */
// Checker for the merge-insertion sorter: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module merge_insertion_sorter_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  msort_item_if          item_mon,
  msort_result_if        result_mon,
  output int             fail_count_o,
  output int             pending_o
);

  typedef logic [msort_pkg::VAL_W-1:0] val_t;

  typedef struct packed {
    val_t sorted_value;
    logic final_res;
  } sorted_res_t;

  // Values of the set still open, kept in ascending order
  val_t        open_set_q[$];
  // Sorted results owed by the block, oldest first
  sorted_res_t sorted_res_q[$];
  int          fail_count;
  int          pending_count;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Place a value after every held value not greater than it; release the set when closed
  task automatic absorb_item(input val_t v, input logic closes);
    int          pos;
    sorted_res_t res;
    pos = open_set_q.size();
    while (pos > 0 && open_set_q[pos-1] > v) pos--;
    open_set_q.insert(pos, v);
    if (closes || open_set_q.size() >= CAPACITY) begin
      foreach (open_set_q[i]) begin
        res.sorted_value = open_set_q[i];
        res.final_res    = (i == open_set_q.size() - 1);
        sorted_res_q.insert(sorted_res_q.size(), res);
      end
      open_set_q.delete();
    end
  endtask

  // Compare one result transaction with the oldest sorted value owed
  task automatic check_result(input val_t act_value, input logic act_final);
    sorted_res_t exp;
    if (sorted_res_q.size() == 0) begin
      $display("%0t: unexpected result: sorted_value=%0d final_res=%b",
               $time, act_value, act_final);
      fail_count++;
    end else begin
      exp = sorted_res_q.pop_front();
      if (act_value !== exp.sorted_value) begin
        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                 $time, exp.sorted_value, act_value);
        fail_count++;
      end
      if (act_final !== exp.final_res) begin
        $display("%0t: final_res mismatch: expected %b, actual %b",
                 $time, exp.final_res, act_final);
        fail_count++;
      end
    end
  endtask

  // Sample transactions at the rising edge, inputs first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_mon.valid && item_mon.ready)
        absorb_item(item_mon.value, item_mon.last);
      if (result_mon.valid && result_mon.ready)
        check_result(result_mon.sorted_value, result_mon.final_res);
      pending_count = sorted_res_q.size();
    end
  end

endmodule

/* bench/merge_insertion_sorter_tb.sv */
// Top of the merge-insertion sorter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module merge_insertion_sorter_tb;

  localparam int unsigned CAPACITY    = 64;
  localparam int          HOLD_CYCLES = 300;
  localparam int          IDLE_LIMIT  = 5000;
  localparam int          PHASE_ITEMS = 3;

  typedef logic [msort_pkg::VAL_W-1:0] val_t;
  localparam val_t VAL_MAX = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  msort_item_if   item_if();
  msort_result_if result_if();

  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_seq;
  val_t set_vals[$];

  merge_insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  merge_insertion_sorter_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_mon    (item_if),
    .result_mon  (result_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (item_if.valid && item_if.ready) ||
          (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[merge_insertion_sorter] ERROR");
    $finish;
  end

  function automatic val_t rand_value();
    val_t v;
    case ($urandom_range(3))
      0: v = val_t'($urandom_range(15));
      1: v = VAL_MAX - val_t'($urandom_range(3));
      default: v = val_t'($urandom);
    endcase
    return v;
  endfunction

  // Offer one value; called and returning at a falling edge
  task automatic send_item(input val_t v, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.value <= v;
    item_if.last  <= closes;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send the queued set; the final value carries the given last flag
  task automatic send_set_vals(input logic close_last);
    foreach (set_vals[i])
      send_item(set_vals[i], (i == set_vals.size() - 1) ? close_last : 1'b0);
  endtask

  task automatic build_random_set(input int n);
    set_vals.delete();
    repeat (n) set_vals.insert(set_vals.size(), rand_value());
  endtask

  // Drop valid and hold until every sorted value owed has arrived
  task automatic drain();
    item_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  initial begin
    int         sent;
    int         n;
    idle_mode_e mode;

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq       = 0;
    rst_ni         = 1'b0;
    item_if.valid <= 1'b0;
    item_if.value <= '0;
    item_if.last  <= 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single-value sets at both extremes
    set_vals = '{val_t'(0)};
    send_set_vals(1'b1);
    set_vals = '{VAL_MAX};
    send_set_vals(1'b1);
    // Directed: extremes, alternating bit patterns and duplicates
    set_vals = '{VAL_MAX, val_t'(0), val_t'(31'h2AAA_AAAA), val_t'(31'h5555_5555),
                 val_t'(7), val_t'(7), val_t'(7), val_t'(1)};
    send_set_vals(1'b1);
    // Directed: descending order forces the longest shifts, ascending none
    set_vals = '{val_t'(10), val_t'(9), val_t'(8), val_t'(7), val_t'(6), val_t'(5)};
    send_set_vals(1'b1);
    set_vals = '{val_t'(1), val_t'(2), val_t'(3), val_t'(4)};
    send_set_vals(1'b1);
    drain();

    // Random sets under each idling mode, draining between modes
    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      mode = idle_mode_e'(m);
      case (mode)
        IDLE_SEND: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        IDLE_BOTH: begin send_idle_pct = 18; recv_stall_pct = 18; end
        default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(16, 1) : $urandom_range(8, 1);
        build_random_set(n);
        send_set_vals(1'b1);
        sent += n;
      end
      // Fill the store: the set closes on the last free entry whatever its flag
      if (mode == IDLE_NONE) begin
        build_random_set(CAPACITY);
        send_set_vals(1'($urandom_range(1)));
      end
      drain();
    end

    // Hold the receiver off while sets keep coming, so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq++;
    repeat (2) begin
      build_random_set($urandom_range(6, 3));
      send_set_vals(1'b1);
    end
    drain();

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[merge_insertion_sorter] OK");
    else
      $display("[merge_insertion_sorter] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/msort_pkg.sv
rtl/msort_item_if.sv
rtl/msort_result_if.sv
rtl/msort_dpath.sv
rtl/msort_ctrl.sv
rtl/merge_insertion_sorter.sv
bench/merge_insertion_sorter_checker.sv
bench/merge_insertion_sorter_tb.sv
